/* sv/tbpf_pkg.sv */
`timescale 1ns / 1ps
// Shared constants, types and helpers for the tiled background pixel fetch block.
// Used by every module of the block; depends on nothing else.
package tbpf_pkg;

	localparam int VIDEO_HALFWORDS = 65536;
	localparam int VRAM_AW = $clog2(VIDEO_HALFWORDS);
	// One more bit than the memory address, so that an index past the end can be seen.
	localparam int VRAM_IW = VRAM_AW + 1;
	localparam logic [VRAM_IW-1:0] VRAM_LIMIT = VRAM_IW'(VIDEO_HALFWORDS);

	localparam int SCREEN_COLUMNS = 240;

	localparam int PAL_ENTRIES = 256;
	localparam int PAL_AW = $clog2(PAL_ENTRIES);

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW = FIFO_AW + 1;

	typedef enum logic [1:0] {
		OP_VRAM_WR = 2'd0,
		OP_PAL_WR  = 2'd1,
		OP_RENDER  = 2'd2
	} opcode_t;

	localparam logic CFG_SCREEN_BASE = 1'b0;
	localparam logic CFG_CHAR_BASE   = 1'b1;

	typedef struct packed {
		logic               we;
		logic               re;
		logic [VRAM_AW-1:0] addr;
		logic [15:0]        wdata;
	} vram_req_t;

	typedef struct packed {
		logic              we;
		logic [PAL_AW-1:0] waddr;
		logic [15:0]       wdata;
		logic              re;
		logic [PAL_AW-1:0] raddr;
	} pal_req_t;

	typedef struct packed {
		logic [15:0] pixel_index;
		logic [31:0] pixel_color;
	} pix_t;

	// 15-bit BGR to a colour word with red, green and blue in the top three bytes.
	function automatic logic [31:0] expand_bgr(input logic [15:0] bgr);
		return {bgr[4:0], 3'b000, bgr[9:5], 3'b000, bgr[14:10], 3'b000, 8'h00};
	endfunction

endpackage

/* sv/tbpf_vram.sv */
`timescale 1ns / 1ps
// Single-port video memory of 16-bit halfwords with a registered read.
// Depends on tbpf_pkg for its depth and request type.
module tbpf_vram (
	input  logic                clk,
	input  tbpf_pkg::vram_req_t req,
	output logic [15:0]         rdata
);

	logic [15:0] mem [tbpf_pkg::VIDEO_HALFWORDS];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.addr] <= req.wdata;
		end else if (req.re) begin
			rdata <= mem[req.addr];
		end
	end

endmodule

/* sv/tbpf_palette.sv */
`timescale 1ns / 1ps
// Background palette memory: one write and one registered read per cycle.
// A read and a write to the same entry in one cycle return the old value.
// Depends on tbpf_pkg for its depth and request type.
module tbpf_palette (
	input  logic               clk,
	input  tbpf_pkg::pal_req_t req,
	output logic [15:0]        rdata
);

	logic [15:0] mem [tbpf_pkg::PAL_ENTRIES];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (req.re) begin
			rdata <= mem[req.raddr];
		end
	end

endmodule

/* sv/tbpf_out_fifo.sv */
`timescale 1ns / 1ps
// Small result queue that decouples the render pipeline from the output stall.
// Depends on tbpf_pkg for its depth and entry type.
module tbpf_out_fifo (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	input  tbpf_pkg::pix_t                din,
	input  logic                          pop,
	output tbpf_pkg::pix_t                dout,
	output logic                          not_empty,
	output logic [tbpf_pkg::FIFO_CW-1:0]  count
);

	tbpf_pkg::pix_t                 entries [tbpf_pkg::FIFO_DEPTH];
	logic [tbpf_pkg::FIFO_AW-1:0]   wr_ptr_q;
	logic [tbpf_pkg::FIFO_AW-1:0]   rd_ptr_q;
	logic [tbpf_pkg::FIFO_CW-1:0]   count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			entries[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign dout      = entries[rd_ptr_q];
	assign not_empty = (count_q != '0);
	assign count     = count_q;

endmodule

/* sv/tiled_bg_pixel_fetch.sv */
`timescale 1ns / 1ps
// Top level of the tiled background pixel fetch block: request decode, the
// render pipeline around the video memory and palette, and the result queue.
// Depends on tbpf_pkg, tbpf_vram, tbpf_palette and tbpf_out_fifo.
//
// A render request uses the single video memory port twice: the tile map
// entry is read in the cycle the request is accepted and the tile pixel byte
// in the next, and the request stall is high while the tile byte is read, so
// no other request is accepted then. Video and palette writes are carried out
// in the cycle they are accepted. The colour of a render passes the tile map,
// tile byte and palette reads and is offered through a four-entry result
// queue; any request is also stalled while the queued results together with
// the renders still in flight already take up all four entries. Memory
// contents are not cleared at reset and must be written before they are read.
// Configuration writes are registered and apply to reads issued after them.
module tiled_bg_pixel_fetch (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [4:0]  cfg_data,

	input  logic        req_valid,
	output logic        req_stall,
	input  logic [1:0]  opcode,
	input  logic [15:0] mem_index,
	input  logic [15:0] write_value,
	input  logic [7:0]  pixel_x,
	input  logic [7:0]  pixel_y,

	output logic        pix_valid,
	input  logic        pix_stall,
	output logic [15:0] pixel_index,
	output logic [31:0] pixel_color
);

	logic [4:0] screen_base_q;
	logic [1:0] char_base_q;

	logic req_acc;
	logic is_render;
	logic vram_wr_ok;

	logic [tbpf_pkg::VRAM_IW-1:0] map_idx;
	logic [tbpf_pkg::VRAM_IW-1:0] tile_idx;
	logic [15:0]                  map_entry;
	logic [15:0]                  tile_word;
	logic [7:0]                   tile_byte;
	logic [3:0]                   tile_nib;

	// Stage 1: tile map read outstanding.
	logic        v_s1;
	logic        oob_s1;
	logic [2:0]  xl_s1;
	logic [2:0]  yl_s1;
	logic [15:0] pidx_s1;
	// Stage 2: tile byte read outstanding.
	logic        v_s2;
	logic        oob_s2;
	logic [3:0]  bank_s2;
	logic [1:0]  xsel_s2;
	logic [15:0] pidx_s2;
	// Stage 3: palette read outstanding.
	logic        v_s3;
	logic [15:0] pidx_s3;

	tbpf_pkg::vram_req_t vreq;
	tbpf_pkg::pal_req_t  preq;
	logic [15:0]         vram_rdata;
	logic [15:0]         pal_rdata;

	tbpf_pkg::pix_t               fifo_din;
	tbpf_pkg::pix_t               fifo_dout;
	logic                         fifo_not_empty;
	logic [tbpf_pkg::FIFO_CW-1:0] fifo_count;
	logic [tbpf_pkg::FIFO_CW-1:0] occupancy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_base_q <= '0;
			char_base_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				tbpf_pkg::CFG_SCREEN_BASE: screen_base_q <= cfg_data;
				tbpf_pkg::CFG_CHAR_BASE:   char_base_q   <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	// Renders still in the pipeline will each need a queue entry.
	assign occupancy = fifo_count + tbpf_pkg::FIFO_CW'(v_s1)
		+ tbpf_pkg::FIFO_CW'(v_s2) + tbpf_pkg::FIFO_CW'(v_s3);
	assign req_stall = v_s1 || (occupancy >= tbpf_pkg::FIFO_CW'(tbpf_pkg::FIFO_DEPTH));
	assign req_acc   = req_valid && !req_stall;
	assign is_render = (opcode == tbpf_pkg::OP_RENDER);

	assign vram_wr_ok = ({1'b0, mem_index} < tbpf_pkg::VRAM_LIMIT);

	assign map_idx = tbpf_pkg::VRAM_IW'({screen_base_q, pixel_y[7:3], pixel_x[7:3]});

	// An entry read past the end of video memory reads as zero.
	assign map_entry = oob_s1 ? 16'h0000 : vram_rdata;
	assign tile_idx  = tbpf_pkg::VRAM_IW'({char_base_q, 13'h0000})
		+ tbpf_pkg::VRAM_IW'({map_entry[9:0], 4'h0})
		+ tbpf_pkg::VRAM_IW'({yl_s1, xl_s1[2]});

	// The tile read in stage 1 has the port to itself, as the request side is stalled then.
	always_comb begin
		vreq = '0;
		if (v_s1) begin
			vreq.re   = 1'b1;
			vreq.addr = tile_idx[tbpf_pkg::VRAM_AW-1:0];
		end else if (req_acc && is_render) begin
			vreq.re   = 1'b1;
			vreq.addr = map_idx[tbpf_pkg::VRAM_AW-1:0];
		end else if (req_acc && (opcode == tbpf_pkg::OP_VRAM_WR) && vram_wr_ok) begin
			vreq.we    = 1'b1;
			vreq.addr  = mem_index[tbpf_pkg::VRAM_AW-1:0];
			vreq.wdata = write_value;
		end
	end

	tbpf_vram u_vram (
		.clk   (clk),
		.req   (vreq),
		.rdata (vram_rdata)
	);

	assign tile_word = oob_s2 ? 16'h0000 : vram_rdata;
	assign tile_byte = xsel_s2[1] ? tile_word[15:8] : tile_word[7:0];
	assign tile_nib  = xsel_s2[0] ? tile_byte[7:4] : tile_byte[3:0];

	always_comb begin
		preq       = '0;
		preq.we    = req_acc && (opcode == tbpf_pkg::OP_PAL_WR) && (mem_index[15:8] == 8'h00);
		preq.waddr = mem_index[tbpf_pkg::PAL_AW-1:0];
		preq.wdata = write_value;
		preq.re    = v_s2;
		preq.raddr = {bank_s2, tile_nib};
	end

	tbpf_palette u_palette (
		.clk   (clk),
		.req   (preq),
		.rdata (pal_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= req_acc && is_render;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		oob_s1  <= (map_idx >= tbpf_pkg::VRAM_LIMIT);
		xl_s1   <= pixel_x[2:0];
		yl_s1   <= pixel_y[2:0];
		pidx_s1 <= 16'(16'(pixel_y) * 16'(tbpf_pkg::SCREEN_COLUMNS)) + 16'(pixel_x);

		oob_s2  <= (tile_idx >= tbpf_pkg::VRAM_LIMIT);
		bank_s2 <= map_entry[15:12];
		xsel_s2 <= xl_s1[1:0];
		pidx_s2 <= pidx_s1;

		pidx_s3 <= pidx_s2;
	end

	assign fifo_din.pixel_index = pidx_s3;
	assign fifo_din.pixel_color = tbpf_pkg::expand_bgr(pal_rdata);

	tbpf_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (v_s3),
		.din       (fifo_din),
		.pop       (fifo_not_empty && !pix_stall),
		.dout      (fifo_dout),
		.not_empty (fifo_not_empty),
		.count     (fifo_count)
	);

	assign pix_valid   = fifo_not_empty;
	assign pixel_index = fifo_dout.pixel_index;
	assign pixel_color = fifo_dout.pixel_color;

endmodule
